// ----- rtl/kabf_pkg.sv -----
package kabf_pkg;

    localparam int DATA_W        = 32;
    localparam int CFG_W         = 17;
    localparam int CFG_IDX_W     = 2;
    localparam int NUM_AXES_DEF  = 2;
    localparam int FRAC_BITS_DEF = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd3;

    localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

    // saturate an exact sum to 32 bits
    function automatic logic signed [DATA_W-1:0] sat35(input logic signed [34:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX)
            r = 32'sh7FFFFFFF;
        else if (v < SAT_MIN)
            r = 32'sh80000000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [34:0] ext35(input logic signed [DATA_W-1:0] v);
        return {{3{v[DATA_W-1]}}, v};
    endfunction

endpackage

// ----- rtl/kabf_sample_if.sv -----
interface kabf_sample_if;
    import kabf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     axis;
    logic signed [DATA_W-1:0] accel_angle;
    logic signed [DATA_W-1:0] gyro_rate;

    modport source (output valid, output axis, output accel_angle, output gyro_rate,
                    input ready);
    modport sink   (input valid, input axis, input accel_angle, input gyro_rate,
                    output ready);
endinterface

// ----- rtl/kabf_estimate_if.sv -----
interface kabf_estimate_if;
    import kabf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     result_axis;
    logic signed [DATA_W-1:0] angle_estimate;

    modport source (output valid, output result_axis, output angle_estimate, input ready);
    modport sink   (input valid, input result_axis, input angle_estimate, output ready);
endinterface

// ----- rtl/kabf_div.sv -----
// Restoring signed divider: quot = sat32((num << FRAC_BITS) / den), toward zero; den = 0 gives 0.
module kabf_div import kabf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] num,
    input  logic signed [DATA_W-1:0] den,
    output logic                     done,
    output logic signed [DATA_W-1:0] quot
);
    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW-1:0] Q_LIM = NW'(33'h080000000);

    logic [NW-1:0]     dvd_reg, quo_reg;
    logic [DATA_W-1:0] rem_reg, dmag_reg;
    logic              neg_reg, zero_reg, busy_reg, done_reg;
    logic [CW-1:0]     cnt_reg;

    logic [DATA_W-1:0] nmag, dmag;
    logic [DATA_W:0]   rem_sh, diff;
    logic              ge;

    assign nmag   = num[DATA_W-1] ? DATA_W'(-num) : num;
    assign dmag   = den[DATA_W-1] ? DATA_W'(-den) : den;
    assign rem_sh = {rem_reg, dvd_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, dmag_reg};
    assign ge     = rem_sh >= {1'b0, dmag_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= {nmag, {FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                quo_reg  <= '0;
                dmag_reg <= dmag;
                neg_reg  <= num[DATA_W-1] ^ den[DATA_W-1];
                zero_reg <= (den == '0);
            end
            else if (busy_reg) begin
                rem_reg <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                quo_reg <= {quo_reg[NW-2:0], ge};
                dvd_reg <= {dvd_reg[NW-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;

    always_comb begin
        if (zero_reg)
            quot = '0;
        else if (!neg_reg)
            quot = (quo_reg >= Q_LIM) ? 32'sh7FFFFFFF : quo_reg[DATA_W-1:0];
        else
            quot = (quo_reg > Q_LIM) ? 32'sh80000000 : DATA_W'(-quo_reg[DATA_W-1:0]);
    end
endmodule

// ----- rtl/kalman_angle_bias_filter.sv -----
// The block takes one sample at a time: the next sample beat is taken only in
// the idle cycle after the estimate is handed to the output register.
// The shared multiplier runs 11 products through its MUL and ACC states; the
// bit-serial divider computes the two gains one after the other.
// A stalled receiver holds the sequencer in its final state.
// Reset (rst_n, async low) zeroes all axis banks and loads the default registers.
module kalman_angle_bias_filter import kabf_pkg::*;
#(
    parameter int NUM_AXES  = NUM_AXES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    kabf_sample_if.sink          sample,
    kabf_estimate_if.source      estimate,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);
    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam logic [CFG_W-1:0] RST_DT = CFG_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [CFG_W-1:0] RST_QB =
        CFG_W'(((64'd3 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [65:0] RND    = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] MAX66  = 66'sd2147483647;
    localparam logic signed [65:0] MIN66  = -66'sd2147483648;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_DIV0 = 3'd4;
    localparam logic [2:0] ST_DIV1 = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    // product slots, in program order
    localparam logic [3:0] K_ANG  = 4'd0;   // dt*(rate-bias)
    localparam logic [3:0] K_P00A = 4'd1;   // dt*(p10+p01)
    localparam logic [3:0] K_P00B = 4'd2;   // q_angle*dt
    localparam logic [3:0] K_P11D = 4'd3;   // dt*p11
    localparam logic [3:0] K_P11Q = 4'd4;   // q_bias*dt
    localparam logic [3:0] K_UANG = 4'd5;   // k0*y
    localparam logic [3:0] K_UBIA = 4'd6;   // k1*y
    localparam logic [3:0] K_U00  = 4'd7;   // k0*o00
    localparam logic [3:0] K_U01  = 4'd8;   // k0*o01
    localparam logic [3:0] K_U10  = 4'd9;   // k1*o00
    localparam logic [3:0] K_U11  = 4'd10;  // k1*o01

    function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [65:0] p);
        logic signed [65:0] t;
        logic signed [DATA_W-1:0] r;
        t = (p + RND) >>> FRAC_BITS;
        if (t > MAX66)
            r = 32'sh7FFFFFFF;
        else if (t < MIN66)
            r = 32'sh80000000;
        else
            r = t[DATA_W-1:0];
        return r;
    endfunction

    // configuration
    logic [CFG_W-1:0] dt_reg, qa_reg, qb_reg, rm_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dt_reg <= RST_DT;
            qa_reg <= RST_DT;
            qb_reg <= RST_QB;
            rm_reg <= RST_DT;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_TIME_STEP:     dt_reg <= cfg_wdata;
                REG_ANGLE_NOISE:   qa_reg <= cfg_wdata;
                REG_BIAS_NOISE:    qb_reg <= cfg_wdata;
                REG_MEASURE_NOISE: rm_reg <= cfg_wdata;
                default:           dt_reg <= dt_reg;
            endcase
        end
    end

    // per-axis banks
    logic signed [DATA_W-1:0] ang_bank [NUM_AXES];
    logic signed [DATA_W-1:0] bia_bank [NUM_AXES];
    logic signed [DATA_W-1:0] p00_bank [NUM_AXES];
    logic signed [DATA_W-1:0] p01_bank [NUM_AXES];
    logic signed [DATA_W-1:0] p10_bank [NUM_AXES];
    logic signed [DATA_W-1:0] p11_bank [NUM_AXES];

    logic [2:0]               state_reg;
    logic [3:0]               k_reg;
    logic                     axis_reg;
    logic [AXW-1:0]           idx;
    logic signed [DATA_W-1:0] meas_reg, rate_reg;
    logic signed [DATA_W-1:0] ang_reg, bia_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [DATA_W-1:0] tmp_reg, y_reg, s_reg, k0_reg, k1_reg, o00_reg, o01_reg;
    logic signed [34:0]       acc_reg;
    logic signed [65:0]       prod_reg;
    logic signed [32:0]       op_a, op_b;
    logic signed [DATA_W-1:0] r;
    logic                     div_start_reg, div_start_next, div_done;
    logic signed [DATA_W-1:0] div_q, div_num;

    logic                     est_valid_reg, est_axis_reg;
    logic signed [DATA_W-1:0] est_angle_reg;
    logic                     take, emit;

    assign idx  = AXW'(axis_reg);
    assign take = sample.valid && sample.ready;
    assign emit = (state_reg == ST_FIN) && (!est_valid_reg || estimate.ready);
    assign r    = rnd_sat(prod_reg);

    // divider kicks: first gain after the last predict product, second when the first ends
    assign div_start_next = ((state_reg == ST_ACC) && (k_reg == K_P11Q)) ||
                            ((state_reg == ST_DIV0) && div_done);

    assign sample.ready            = (state_reg == ST_IDLE);
    assign estimate.valid          = est_valid_reg;
    assign estimate.result_axis    = est_axis_reg;
    assign estimate.angle_estimate = est_angle_reg;

    // shared multiplier operand select
    always_comb begin
        op_a = $signed({16'b0, dt_reg});
        op_b = 33'(tmp_reg);
        unique case (k_reg)
            K_ANG, K_P00A: op_b = 33'(tmp_reg);
            K_P00B:        op_b = $signed({16'b0, qa_reg});
            K_P11D:        op_b = 33'(p11_reg);
            K_P11Q:        op_b = $signed({16'b0, qb_reg});
            K_UANG:
            begin
                op_a = 33'(k0_reg);
                op_b = 33'(y_reg);
            end
            K_UBIA:
            begin
                op_a = 33'(k1_reg);
                op_b = 33'(y_reg);
            end
            K_U00:
            begin
                op_a = 33'(k0_reg);
                op_b = 33'(o00_reg);
            end
            K_U01:
            begin
                op_a = 33'(k0_reg);
                op_b = 33'(o01_reg);
            end
            K_U10:
            begin
                op_a = 33'(k1_reg);
                op_b = 33'(o00_reg);
            end
            K_U11:
            begin
                op_a = 33'(k1_reg);
                op_b = 33'(o01_reg);
            end
            default:       op_b = 33'(tmp_reg);
        endcase
    end

    assign div_num = (state_reg == ST_DIV1) ? p10_reg : p00_reg;

    kabf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num),
        .den   (s_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // payload datapath
    always_ff @(posedge clk) begin
        if (take) begin
            axis_reg <= sample.axis;
            meas_reg <= sample.accel_angle;
            rate_reg <= sample.gyro_rate;
        end
        if (state_reg == ST_LOAD) begin
            ang_reg <= ang_bank[idx];
            bia_reg <= bia_bank[idx];
            p00_reg <= p00_bank[idx];
            p01_reg <= p01_bank[idx];
            p10_reg <= p10_bank[idx];
            p11_reg <= p11_bank[idx];
            tmp_reg <= sat35(ext35(rate_reg) - ext35(bia_bank[idx]));
        end
        if (state_reg == ST_MUL)
            prod_reg <= op_a * op_b;
        if (state_reg == ST_ACC) begin
            unique case (k_reg)
                K_ANG:
                begin
                    ang_reg <= sat35(ext35(ang_reg) + ext35(r));
                    tmp_reg <= sat35(ext35(p10_reg) + ext35(p01_reg));
                end
                K_P00A: acc_reg <= ext35(p00_reg) - ext35(r);
                K_P00B: p00_reg <= sat35(acc_reg + ext35(r));
                K_P11D:
                begin
                    p01_reg <= sat35(ext35(p01_reg) - ext35(r));
                    p10_reg <= sat35(ext35(p10_reg) - ext35(r));
                end
                K_P11Q:
                begin
                    p11_reg <= sat35(ext35(p11_reg) + ext35(r));
                    y_reg   <= sat35(ext35(meas_reg) - ext35(ang_reg));
                    s_reg   <= sat35(ext35(p00_reg) + $signed({18'b0, rm_reg}));
                    o00_reg <= p00_reg;
                    o01_reg <= p01_reg;
                end
                K_UANG: ang_reg <= sat35(ext35(ang_reg) + ext35(r));
                K_UBIA: bia_reg <= sat35(ext35(bia_reg) + ext35(r));
                K_U00:  p00_reg <= sat35(ext35(p00_reg) - ext35(r));
                K_U01:  p01_reg <= sat35(ext35(p01_reg) - ext35(r));
                K_U10:  p10_reg <= sat35(ext35(p10_reg) - ext35(r));
                K_U11:  p11_reg <= sat35(ext35(p11_reg) - ext35(r));
                default: acc_reg <= acc_reg;
            endcase
        end
        if (state_reg == ST_DIV0 && div_done)
            k0_reg <= div_q;
        if (state_reg == ST_DIV1 && div_done)
            k1_reg <= div_q;
        if (emit) begin
            est_axis_reg  <= axis_reg;
            est_angle_reg <= ang_reg;
        end
    end

    // sequencer, banks and output beat
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            div_start_reg <= 1'b0;
            est_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                ang_bank[i] <= '0;
                bia_bank[i] <= '0;
                p00_bank[i] <= '0;
                p01_bank[i] <= '0;
                p10_bank[i] <= '0;
                p11_bank[i] <= '0;
            end
        end
        else begin
            div_start_reg <= div_start_next;
            if (emit)
                est_valid_reg <= 1'b1;
            else if (estimate.ready)
                est_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    // out-of-range axis is dropped with no beat
                    if (take && (32'(sample.axis) < NUM_AXES))
                        state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    k_reg     <= K_ANG;
                    state_reg <= ST_MUL;
                end
                ST_MUL:  state_reg <= ST_ACC;
                ST_ACC:
                begin
                    if (k_reg == K_P11Q)
                        state_reg <= ST_DIV0;
                    else if (k_reg == K_U11)
                        state_reg <= ST_FIN;
                    else
                        state_reg <= ST_MUL;
                    k_reg <= k_reg + 1'b1;
                end
                ST_DIV0:
                begin
                    if (div_done)
                        state_reg <= ST_DIV1;
                end
                ST_DIV1:
                begin
                    if (div_done)
                        state_reg <= ST_MUL;
                end
                ST_FIN:
                begin
                    if (emit) begin
                        ang_bank[idx] <= ang_reg;
                        bia_bank[idx] <= bia_reg;
                        p00_bank[idx] <= p00_reg;
                        p01_bank[idx] <= p01_reg;
                        p10_bank[idx] <= p10_reg;
                        p11_bank[idx] <= p11_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- verif/kabf_checker.sv -----
module kabf_checker import kabf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    kabf_sample_if               sample,
    kabf_estimate_if             estimate,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   fail_count,
    output int                   pending
);

    localparam int FB = FRAC_BITS_DEF;
    localparam int NAX = NUM_AXES_DEF;

    typedef struct {
        logic                     axis;
        logic signed [DATA_W-1:0] angle;
    } estimate_t;

    estimate_t angle_queue[$];

    longint dt_reg, q_angle_reg, q_bias_reg, r_meas_reg;
    logic signed [DATA_W-1:0] angle_st[NAX];
    logic signed [DATA_W-1:0] bias_st[NAX];
    logic signed [DATA_W-1:0] p00_st[NAX];
    logic signed [DATA_W-1:0] p01_st[NAX];
    logic signed [DATA_W-1:0] p10_st[NAX];
    logic signed [DATA_W-1:0] p11_st[NAX];

    function automatic logic signed [DATA_W-1:0] clip(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[DATA_W-1:0];
    endfunction

    // round half up, floor shift
    function automatic logic signed [DATA_W-1:0] qmul(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FB - 1));
        return clip(p >>> FB);
    endfunction

    function automatic logic signed [DATA_W-1:0] qgain(input longint num, input longint den);
        if (den == 0)
            return '0;
        return clip((num <<< FB) / den);
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic filter_step(input logic ax, input longint meas, input longint rate);
        longint a, b, p00, p01, p10, p11, y, s, k0, k1, o00, o01;
        a   = angle_st[ax];
        b   = bias_st[ax];
        p00 = p00_st[ax];
        p01 = p01_st[ax];
        p10 = p10_st[ax];
        p11 = p11_st[ax];
        // predict
        a   = clip(a + qmul(dt_reg, clip(rate - b)));
        p00 = clip(p00 - qmul(dt_reg, clip(p10 + p01)) + qmul(q_angle_reg, dt_reg));
        p01 = clip(p01 - qmul(dt_reg, p11));
        p10 = clip(p10 - qmul(dt_reg, p11));
        p11 = clip(p11 + qmul(q_bias_reg, dt_reg));
        // update, covariance from prior p00/p01
        y   = clip(meas - a);
        s   = clip(p00 + r_meas_reg);
        k0  = qgain(p00, s);
        k1  = qgain(p10, s);
        a   = clip(a + qmul(k0, y));
        b   = clip(b + qmul(k1, y));
        o00 = p00;
        o01 = p01;
        p00 = clip(p00 - qmul(k0, o00));
        p01 = clip(p01 - qmul(k0, o01));
        p10 = clip(p10 - qmul(k1, o00));
        p11 = clip(p11 - qmul(k1, o01));
        angle_st[ax] = a[DATA_W-1:0];
        bias_st[ax]  = b[DATA_W-1:0];
        p00_st[ax]   = p00[DATA_W-1:0];
        p01_st[ax]   = p01[DATA_W-1:0];
        p10_st[ax]   = p10[DATA_W-1:0];
        p11_st[ax]   = p11[DATA_W-1:0];
        angle_queue.push_back('{axis: ax, angle: a[DATA_W-1:0]});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        estimate_t e;
        if (!rst_n)
        begin
            dt_reg      = 655;
            q_angle_reg = 655;
            q_bias_reg  = 20;
            r_meas_reg  = 655;
            for (int i = 0; i < NAX; i++)
            begin
                angle_st[i] = '0;
                bias_st[i]  = '0;
                p00_st[i]   = '0;
                p01_st[i]   = '0;
                p10_st[i]   = '0;
                p11_st[i]   = '0;
            end
            angle_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TIME_STEP:     dt_reg      = cfg_wdata;
                    REG_ANGLE_NOISE:   q_angle_reg = cfg_wdata;
                    REG_BIAS_NOISE:    q_bias_reg  = cfg_wdata;
                    REG_MEASURE_NOISE: r_meas_reg  = cfg_wdata;
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready)
                filter_step(sample.axis, longint'(sample.accel_angle),
                            longint'(sample.gyro_rate));
            if (estimate.valid && estimate.ready)
            begin
                if (angle_queue.size() == 0)
                    report("unexpected beat", estimate.angle_estimate, 0);
                else
                begin
                    e = angle_queue.pop_front();
                    if (estimate.result_axis !== e.axis)
                        report("result_axis", estimate.result_axis, e.axis);
                    if (estimate.angle_estimate !== e.angle)
                        report("angle_estimate", estimate.angle_estimate, e.angle);
                end
            end
        end
        pending = angle_queue.size();
    end

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

endmodule

// ----- verif/kalman_angle_bias_filter_test.sv -----
module kalman_angle_bias_filter_test;
    import kabf_pkg::*;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int fail_count;
    int pending;

    // long receiver hold-off requests: top bumps, ready process serves
    int hold_req;
    int hold_done;

    kabf_sample_if   sample_bus();
    kabf_estimate_if estimate_bus();

    kalman_angle_bias_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_bus),
        .estimate  (estimate_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    kabf_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_bus),
        .estimate   (estimate_bus),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;
    always
        #1 clk = ~clk;

    // generous cap: nominal run is well under a third of this
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: stretches of always-ready, random, and mostly-stalled,
    // plus a long counted hold-off on request
    initial
    begin
        int mode;
        int stretch;
        int hold_left;
        estimate_bus.ready <= 1'b0;
        mode      = 0;
        stretch   = 0;
        hold_left = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_req)
            begin
                hold_done = hold_req;
                hold_left = 800;
            end
            if (stretch == 0)
            begin
                mode    = $urandom_range(0, 2);
                stretch = $urandom_range(20, 400);
            end
            stretch--;
            if (hold_left > 0)
            begin
                hold_left--;
                estimate_bus.ready <= 1'b0;
            end
            else if (mode == 0)
                estimate_bus.ready <= 1'b1;
            else if (mode == 1)
                estimate_bus.ready <= 1'($urandom_range(0, 1));
            else
                estimate_bus.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // drive one sample beat, return after it is taken; valid stays high
    task automatic send_sample(input logic ax, input logic [31:0] acc, input logic [31:0] rate);
        sample_bus.valid       <= 1'b1;
        sample_bus.axis        <= ax;
        sample_bus.accel_angle <= acc;
        sample_bus.gyro_rate   <= rate;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        sample_bus.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // registers written back to back, idle block only
    task automatic load_regs(input logic [CFG_W-1:0] dt, input logic [CFG_W-1:0] qa,
                             input logic [CFG_W-1:0] qb, input logic [CFG_W-1:0] rm);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TIME_STEP;
        cfg_wdata <= dt;
        @(posedge clk);
        cfg_index <= REG_ANGLE_NOISE;
        cfg_wdata <= qa;
        @(posedge clk);
        cfg_index <= REG_BIAS_NOISE;
        cfg_wdata <= qb;
        @(posedge clk);
        cfg_index <= REG_MEASURE_NOISE;
        cfg_wdata <= rm;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // angle mostly within +-180 deg, rate within +-2000 dps; sometimes raw 32 bits
    function automatic logic [31:0] pick_angle();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 360 << 16)) - (180 << 16);
    endfunction

    function automatic logic [31:0] pick_rate();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 4000 << 16)) - (2000 << 16);
    endfunction

    task automatic random_burst_phase(input int count, input bit with_hold);
        int burst;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                send_sample(1'($urandom_range(0, 1)), pick_angle(), pick_rate());
                sent++;
                // receiver goes quiet while we keep offering beats
                if (with_hold && sent == 10)
                    hold_req++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 200));
        end
    endtask

    initial
    begin
        logic [31:0] edge_vals[5];
        int n;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= REG_TIME_STEP;
        cfg_wdata              <= '0;
        sample_bus.valid       <= 1'b0;
        sample_bus.axis        <= 1'b0;
        sample_bus.accel_angle <= '0;
        sample_bus.gyro_rate   <= '0;
        hold_req = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes on both axes, default registers
        edge_vals = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00010000};
        for (int i = 0; i < 5; i++)
        begin
            send_sample(i[0], edge_vals[i], edge_vals[4 - i]);
            send_sample(~i[0], edge_vals[(i + 2) % 5], edge_vals[i]);
        end
        drain();

        // directed: extreme registers, incl. zero noises and zero measure noise
        // (the innovation variance can then hit zero and both gains vanish)
        load_regs(17'd65536, 17'd0, 17'd0, 17'd1);
        send_sample(1'b0, 32'h7FFFFFFF, 32'h80000000);
        send_sample(1'b1, 32'h80000000, 32'h7FFFFFFF);
        send_sample(1'b0, 32'h0, 32'h0);
        drain();
        load_regs(17'd1, 17'd65536, 17'd65536, 17'd65536);
        send_sample(1'b1, 32'h00100000, 32'hFFF00000);
        send_sample(1'b0, 32'h80000000, 32'h80000000);
        drain();
        load_regs(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'd0);
        send_sample(1'b0, 32'h0, 32'h0);
        send_sample(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_sample(1'b0, 32'h00050000, 32'h0);
        drain();

        // random phases, each under its own register setting; the sender
        // pauses at every boundary until all estimates are back
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: load_regs(17'd655, 17'd655, 17'd20, 17'd655);
                1: load_regs(17'd1, 17'd0, 17'd0, 17'd1);
                2: load_regs(17'd65536, 17'd65536, 17'd65536, 17'd65536);
                3: load_regs(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
                default: load_regs(CFG_W'($urandom_range(1, 65536)),
                                   CFG_W'($urandom_range(0, 65536)),
                                   CFG_W'($urandom_range(0, 65536)),
                                   CFG_W'($urandom_range(1, 65536)));
            endcase
            n = 150;
            random_burst_phase(n, ph == 2);
            drain();
        end

        drain();
        repeat (150) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
